// ----- design/mexp_pkg.sv -----
package mexp_pkg;

  // field widths
  localparam int BaseW = 30;
  localparam int ExpW  = 32;
  localparam int PowW  = 30;

  // stream payload widths, padded to whole bytes
  localparam int InDataW  = 64;
  localparam int OutDataW = 32;

  // prime modulus and the exponent that gives the inverse
  localparam logic [PowW-1:0] Modulus    = 30'd1000000007;
  localparam logic [ExpW-1:0] InverseExp = 32'd1000000005;

  // multiplier scans one operand bit per cycle
  localparam int MulBits = PowW;
  localparam int CntW    = $clog2(MulBits);

  // one step of interleaved modular multiplication: (2*r + a) mod p
  // r and a are both below the modulus
  function automatic logic [PowW-1:0] mod_step(input logic [PowW-1:0] r,
                                              input logic [PowW-1:0] a);
    logic [PowW:0] dbl;
    logic [PowW:0] sum;
    dbl = {r, 1'b0};
    if (dbl >= {1'b0, Modulus}) dbl = dbl - {1'b0, Modulus};
    sum = {1'b0, dbl[PowW-1:0]} + {1'b0, a};
    if (sum >= {1'b0, Modulus}) sum = sum - {1'b0, Modulus};
    return sum[PowW-1:0];
  endfunction

endpackage

// ----- design/modular_exponentiation_core.sv -----
// flow: after the input transfer, each bit of the effective exponent (at most 31 bits) takes
//   one S_STEP and one S_MUL pass; a final S_STEP leads to S_FINISH, which loads the result
// one item at a time: no new input is taken until the result is loaded; each exponent bit
//   costs one pass of the bit-serial modular multiplier plus one control state
// reset: synchronous, active high; clears the controller and the output valid
module modular_exponentiation_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // base [29:0], exponent [61:30], zeros [63:62]
  input  logic [mexp_pkg::InDataW-1:0]       s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // power [29:0], zeros [31:30]
  output logic [mexp_pkg::OutDataW-1:0]      m_tdata
);
  import mexp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_STEP   = 4'b0010,
    S_MUL    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state;
  logic [PowW-1:0]   acc;
  logic [PowW-1:0]   sq;
  logic [ExpW-1:0]   expo;
  logic [PowW-1:0]   mplier;
  logic [PowW-1:0]   pa;
  logic [PowW-1:0]   ps;
  logic [CntW-1:0]   cnt;
  logic [PowW-1:0]   power;
  logic              out_valid;

  logic [BaseW-1:0]  in_base;
  logic [ExpW-1:0]   in_exp;
  logic [PowW-1:0]   base_red;
  logic [PowW-1:0]   pa_next;
  logic [PowW-1:0]   ps_next;
  logic              out_load;

  assign in_base = s_tdata[BaseW-1:0];
  assign in_exp  = s_tdata[BaseW+ExpW-1:BaseW];

  // base below 2^30 needs at most one subtraction
  assign base_red = (in_base >= Modulus) ? in_base - Modulus : in_base;

  // both products share the current multiplier bit of the square
  assign pa_next = mod_step(pa, mplier[PowW-1] ? acc : '0);
  assign ps_next = mod_step(ps, mplier[PowW-1] ? sq : '0);

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!out_valid || m_tready);

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (s_tvalid) state <= S_STEP;
        S_STEP:   state <= (expo == '0) ? S_FINISH : S_MUL;
        S_MUL:    if (cnt == '0) state <= S_STEP;
        S_FINISH: if (out_load) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath: square-and-multiply, lsb of exponent first; all ones -> inverse, else msb set -> 0
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          sq <= base_red;
          if (in_exp[ExpW-1]) begin
            if (in_exp == '1) begin
              acc  <= PowW'(1);
              expo <= InverseExp;
            end else begin
              acc  <= '0;
              expo <= '0;
            end
          end else begin
            acc  <= PowW'(1);
            expo <= in_exp;
          end
        end
      end
      S_STEP: begin
        mplier <= sq;
        pa     <= '0;
        ps     <= '0;
        cnt    <= CntW'(MulBits - 1);
      end
      S_MUL: begin
        pa     <= pa_next;
        ps     <= ps_next;
        mplier <= {mplier[PowW-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          if (expo[0]) acc <= pa_next;
          sq   <= ps_next;
          expo <= {1'b0, expo[ExpW-1:1]};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) power <= acc;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-PowW){1'b0}}, power};

endmodule

// ----- design/mexp_checker.sv -----
module mexp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mexp_pkg::OutDataW-1:0] m_tdata
);
  import mexp_pkg::*;

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // every result is reduced and the padding is zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OutDataW-1:PowW] == '0) && (m_tdata[PowW-1:0] < Modulus))
    else $error("result out of range");

  // one item at a time: no input transfer right after one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // a result does not appear right after its input transfer, unless an older result is stalled
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !(m_tvalid && !m_tready) |=> !m_tvalid)
    else $error("result appeared too early");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);
